// ===== rtl/bqmp_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded queue with max-pop: shared package
// Transaction types, operation codes and cell control codes.
// ----------------------------------------------------------------------------
package bqmp_pkg;

    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_ROTATE = 2'd2;
    localparam logic [1:0] KIND_MAXPOP = 2'd3;

    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_PUSH   = 2'd1;
    localparam logic [1:0] CELL_SHIFT  = 2'd2;
    localparam logic [1:0] CELL_ROTATE = 2'd3;

    localparam int CAP_BITS  = 5;
    localparam int FIELD_BITS = 16;

    typedef struct packed {
        logic [1:0]                    kind;
        logic signed [FIELD_BITS-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic                          done_res;
        logic signed [FIELD_BITS-1:0]  taken_value;
        logic [CAP_BITS-1:0]           count;
        logic signed [FIELD_BITS-1:0]  head_value;
        logic signed [FIELD_BITS-1:0]  tail_value;
        logic                          is_full;
        logic                          is_empty;
    } res_t;

    typedef struct packed {
        logic [1:0] op;
        logic       at_fill;
        logic       at_tail;
    } cell_ctl_t;

endpackage

// ===== rtl/bqmp_cell.sv =====
// ----------------------------------------------------------------------------
// Bounded queue with max-pop: storage cell
// Holds one queue entry and loads it from the push bus, its right-hand
// neighbor or the head of the queue as the broadcast command selects.
// ----------------------------------------------------------------------------
module bqmp_cell #(
    parameter int ENTRY_BITS = 16
) (
    input  logic                         clk,
    input  bqmp_pkg::cell_ctl_t          ctl,
    input  logic signed [ENTRY_BITS-1:0] push_value,
    input  logic signed [ENTRY_BITS-1:0] head_value,
    input  logic signed [ENTRY_BITS-1:0] right_value,
    output logic signed [ENTRY_BITS-1:0] entry
);

    logic signed [ENTRY_BITS-1:0] entry_reg;
    logic signed [ENTRY_BITS-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            bqmp_pkg::CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            bqmp_pkg::CELL_PUSH:
            begin
                if (ctl.at_fill)
                begin
                    entry_next = push_value;
                end
            end
            bqmp_pkg::CELL_SHIFT:
            begin
                entry_next = right_value;
            end
            bqmp_pkg::CELL_ROTATE:
            begin
                if (ctl.at_tail)
                begin
                    entry_next = head_value;
                end
                else
                begin
                    entry_next = right_value;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/bounded_queue_with_max_pop.sv =====
// ----------------------------------------------------------------------------
// Bounded queue with max-pop: top level
// Ordered queue of signed entries in a chain of cells, with push, pop,
// rotate and removal of the largest entry.
// ----------------------------------------------------------------------------
// Usage: a command transaction (cmd) is taken at a clock edge where start is
// high and busy is low. Exactly one result transaction follows for every
// command; it is presented on res for one cycle while res_valid is high and
// cannot be held off by the receiver.
// Push, pop and rotate update the cell chain at the accepting edge; these
// and every rejected command present the result in the next cycle.
// Max-pop on a non-empty queue rotates the chain once through all held
// entries to find the largest one (the last of equal largest ones), then
// rotates it again while that entry is dropped at the head. Busy stays
// high through the result cycle, so no new command is accepted until the
// result has been presented.
// The capacity register is written through cfg_valid/cfg_ready/cfg_data;
// the user must do so only while no command is in flight (the block does
// not enforce this), and values outside 1..DEPTH are clamped.
// Reset empties the queue and sets the capacity to 16; cell contents are
// left undefined and are never read before being written.
// ----------------------------------------------------------------------------
module bounded_queue_with_max_pop #(
    parameter int DEPTH      = 16,
    parameter int ENTRY_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  bqmp_pkg::cmd_t                      cmd,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bqmp_pkg::CAP_BITS-1:0]       cfg_data,
    output logic                                res_valid,
    output bqmp_pkg::res_t                      res
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DROP   = 2'd2;
    localparam logic [1:0] ST_REPORT = 2'd3;

    logic [1:0]                              state_reg, state_next;
    logic [CW-1:0]                           fill_reg, fill_next;
    logic [CW-1:0]                           n_reg, n_next;
    logic [IW-1:0]                           k_reg, k_next;
    logic [IW-1:0]                           best_idx_reg, best_idx_next;
    logic signed [ENTRY_BITS-1:0]            best_val_reg, best_val_next;
    logic signed [ENTRY_BITS-1:0]            tail_reg, tail_next;
    logic                                    done_reg, done_next;
    logic signed [bqmp_pkg::FIELD_BITS-1:0]  taken_reg, taken_next;
    logic [bqmp_pkg::CAP_BITS-1:0]           cap_reg;

    logic [1:0]                              cell_op;
    logic signed [ENTRY_BITS-1:0]            cell_entry [DEPTH];
    logic signed [ENTRY_BITS-1:0]            cell_right [DEPTH];
    logic signed [ENTRY_BITS-1:0]            head;
    logic signed [ENTRY_BITS-1:0]            push_fit;
    logic [CW-1:0]                           eff_cap;
    logic [CW-1:0]                           tail_pos;
    logic                                    accept;
    logic                                    last_step;

    assign head      = cell_entry[0];
    assign push_fit  = ENTRY_BITS'(cmd.value);
    assign tail_pos  = fill_reg - CW'(1);
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign last_step = (CW'(k_reg) == n_reg - CW'(1));
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (int'(cap_reg) > DEPTH)
        begin
            eff_cap = CW'(DEPTH);
        end
        else
        begin
            eff_cap = CW'(cap_reg);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            bqmp_pkg::cell_ctl_t ctl;

            assign ctl.op      = cell_op;
            assign ctl.at_fill = (fill_reg == CW'(gi));
            assign ctl.at_tail = (tail_pos == CW'(gi));

            if (gi < DEPTH - 1)
            begin : g_mid
                assign cell_right[gi] = cell_entry[gi+1];
            end
            else
            begin : g_end
                assign cell_right[gi] = cell_entry[gi];
            end

            bqmp_cell #(
                .ENTRY_BITS (ENTRY_BITS)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .push_value  (push_fit),
                .head_value  (head),
                .right_value (cell_right[gi]),
                .entry       (cell_entry[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        tail_next     = tail_reg;
        done_next     = done_reg;
        taken_next    = taken_reg;
        cell_op       = bqmp_pkg::CELL_HOLD;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next     = fill_reg;
                    k_next     = '0;
                    done_next  = 1'b0;
                    taken_next = '0;
                    state_next = ST_REPORT;
                    case (cmd.kind)
                        bqmp_pkg::KIND_PUSH:
                        begin
                            if (fill_reg < eff_cap)
                            begin
                                cell_op   = bqmp_pkg::CELL_PUSH;
                                fill_next = fill_reg + CW'(1);
                                tail_next = push_fit;
                                done_next = 1'b1;
                            end
                        end
                        bqmp_pkg::KIND_POP:
                        begin
                            if (fill_reg != '0)
                            begin
                                cell_op    = bqmp_pkg::CELL_SHIFT;
                                fill_next  = fill_reg - CW'(1);
                                taken_next = bqmp_pkg::FIELD_BITS'(head);
                                done_next  = 1'b1;
                            end
                        end
                        bqmp_pkg::KIND_ROTATE:
                        begin
                            if (fill_reg != '0)
                            begin
                                cell_op   = bqmp_pkg::CELL_ROTATE;
                                tail_next = head;
                                done_next = 1'b1;
                            end
                        end
                        bqmp_pkg::KIND_MAXPOP:
                        begin
                            if (fill_reg != '0)
                            begin
                                done_next  = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_REPORT;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cell_op   = bqmp_pkg::CELL_ROTATE;
                tail_next = head;
                if ((k_reg == '0) || (head >= best_val_reg))
                begin
                    best_val_next = head;
                    best_idx_next = k_reg;
                end
                if (last_step)
                begin
                    k_next     = '0;
                    state_next = ST_DROP;
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                end
            end
            ST_DROP:
            begin
                if (k_reg == best_idx_reg)
                begin
                    cell_op    = bqmp_pkg::CELL_SHIFT;
                    fill_next  = fill_reg - CW'(1);
                    taken_next = bqmp_pkg::FIELD_BITS'(head);
                end
                else
                begin
                    cell_op   = bqmp_pkg::CELL_ROTATE;
                    tail_next = head;
                end
                if (last_step)
                begin
                    state_next = ST_REPORT;
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                end
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            cap_reg   <= bqmp_pkg::CAP_BITS'(16);
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        k_reg        <= k_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        tail_reg     <= tail_next;
        done_reg     <= done_next;
        taken_reg    <= taken_next;
    end

    assign res_valid       = (state_reg == ST_REPORT);
    assign res.done_res    = done_reg;
    assign res.taken_value = taken_reg;
    assign res.count       = bqmp_pkg::CAP_BITS'(fill_reg);
    assign res.head_value  = (fill_reg == '0) ? '0 : bqmp_pkg::FIELD_BITS'(head);
    assign res.tail_value  = (fill_reg == '0) ? '0 : bqmp_pkg::FIELD_BITS'(tail_reg);
    assign res.is_full     = (fill_reg >= eff_cap);
    assign res.is_empty    = (fill_reg == '0);

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("queue fill exceeds depth");

    a_simple_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.kind != bqmp_pkg::KIND_MAXPOP)) |=> res_valid)
        else $error("push, pop or rotate did not report in the next cycle");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> !busy)
        else $error("result presented for more than one cycle");

    a_drop_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DROP) |-> ((n_reg == fill_reg) || (n_reg == fill_reg + CW'(1))))
        else $error("max-pop removed more than one entry");

endmodule
